FILE: rtl/lcpie_pkg.sv
// Package for the LCP interval enumerator: item types, state codes and the
// request/response types of the shared label unit. No dependencies.
`default_nettype none

package lcpie_pkg;

    localparam int LCP_W           = 20;
    localparam int CFG_W           = 6;
    localparam int STACK_DEPTH_DEF = 1024;
    localparam int INDEX_BITS_DEF  = 20;

    localparam logic [CFG_W-1:0] MAX_LENGTH_RESET = 6'd6;

    typedef struct packed {
        logic [LCP_W-1:0] lcp_value;
        logic             last;
    } t_in_item;

    typedef struct packed {
        logic [LCP_W-1:0] start_index;
        logic [LCP_W-1:0] end_index;
        logic [LCP_W-1:0] repr_index;
        logic [LCP_W-1:0] label;
        logic [LCP_W-1:0] sil;
        logic             trivial;
        logic             last_result;
        logic             overflow;
    } t_out_item;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_POP,
        ST_LOAD,
        ST_FLUSH
    } t_state;

    // operands of the shared label/compare unit
    typedef struct packed {
        logic [LCP_W-1:0] x;
        logic [LCP_W-1:0] y;
        logic [LCP_W-1:0] bound;
        logic [CFG_W-1:0] limit;
    } t_lbl_req;

    typedef struct packed {
        logic [LCP_W-1:0] label;
        logic             below_bound;
        logic             below_limit;
        logic             y_below_bound;
    } t_lbl_res;

endpackage

`default_nettype wire

FILE: rtl/lcpie_label_unit.sv
// Shared label unit: maximum of two LCP values and the compares against the
// interval bound and the length limit. Uses lcpie_pkg.
`default_nettype none

module lcpie_label_unit (
    input  wire lcpie_pkg::t_lbl_req i_req,
    output lcpie_pkg::t_lbl_res      o_res
);

    logic [lcpie_pkg::LCP_W-1:0] w_label;

    assign w_label = (i_req.x > i_req.y) ? i_req.x : i_req.y;

    always_comb begin
        o_res.label         = w_label;
        o_res.below_bound   = w_label < i_req.bound;
        o_res.below_limit   = w_label < {{(lcpie_pkg::LCP_W - lcpie_pkg::CFG_W){1'b0}},
                                         i_req.limit};
        o_res.y_below_bound = i_req.y < i_req.bound;
    end

endmodule

`default_nettype wire

FILE: rtl/lcpie_stack_mem.sv
// Stack memory of the LCP interval enumerator: one write port, one read port
// with registered read data. No package dependencies.
`default_nettype none

module lcpie_stack_mem #(
    parameter int DEPTH  = 1024,
    parameter int DATA_W = 80
) (
    input  wire                     i_clk,
    input  wire                     i_we,
    input  wire [$clog2(DEPTH)-1:0] i_waddr,
    input  wire [DATA_W-1:0]        i_wdata,
    input  wire [$clog2(DEPTH)-1:0] i_raddr,
    output logic [DATA_W-1:0]       o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

FILE: rtl/lcp_interval_enumerator.sv
// LCP interval enumerator, top level: sequencer, stack top cache, result
// buffering. Uses lcpie_pkg, lcpie_stack_mem and lcpie_label_unit.
//
// Usage: LCP values arrive one per input item (valid/stall), lcp[0] first and
// the closing sentinel lcp[n] with last set. For each later item the block
// emits the trivial interval of the previous position, then the nested intervals
// closed by the new value, on the output channel (valid/stall), each only if its
// label is below max_length. The final result of an item carries last_result;
// overflow is sticky until the end of the sequence. The user must write max_length
// through i_cfg_we/i_cfg_wdata only while the block is idle; the block does not enforce it.
// Sequence: the first item of a sequence is taken in ST_IDLE alone. Any other
// item is accepted in ST_IDLE, which forms the trivial interval; each pop it
// makes is a compare in ST_POP, then a reload of the new top from the single
// read port of the stack memory in ST_LOAD; the push is done in ST_POP and
// ST_FLUSH releases the buffered result. Output stall can hold ST_POP and ST_FLUSH.
// Results go through a one-item hold buffer and an output register, so the
// receiver may stall at any time without loss; the sequencer waits.
// Reset returns the stack to a single bottom entry, clears the position and
// the overflow flag and sets max_length to 6. The stack memory needs no
// clearing pass: every entry is written before it is read.
`default_nettype none

module lcp_interval_enumerator #(
    parameter int STACK_DEPTH = lcpie_pkg::STACK_DEPTH_DEF,
    parameter int INDEX_BITS  = lcpie_pkg::INDEX_BITS_DEF
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_in_valid,
    output logic                             o_in_stall,
    input  wire lcpie_pkg::t_in_item         i_in_item,
    output logic                             o_out_valid,
    input  wire                              i_out_stall,
    output lcpie_pkg::t_out_item             o_out_item,
    input  wire                              i_cfg_we,
    input  wire [lcpie_pkg::CFG_W-1:0]       i_cfg_wdata
);

    localparam int LW   = lcpie_pkg::LCP_W;
    localparam int AW   = $clog2(STACK_DEPTH);
    localparam int SP_W = AW + 1;
    localparam logic [SP_W-1:0] SP_FULL = SP_W'(STACK_DEPTH);
    localparam logic [SP_W-1:0] SP_ONE  = SP_W'(1);

    typedef struct packed {
        logic [INDEX_BITS-1:0] oi;
        logic [LW-1:0]         ol;
        logic [INDEX_BITS-1:0] ii;
        logic [LW-1:0]         il;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    function automatic logic [LW-1:0] to_field(input logic [INDEX_BITS-1:0] v);
        logic [31:0] w;
        w = 32'(v);
        return w[LW-1:0];
    endfunction

    lcpie_pkg::t_state    r_state, n_state;
    logic [lcpie_pkg::CFG_W-1:0] r_max_len;
    logic [LW-1:0]        r_prev, n_prev;
    logic [INDEX_BITS-1:0] r_pos, n_pos;
    logic [SP_W-1:0]      r_sp, n_sp;
    t_entry               r_top, n_top;
    logic                 r_ovf, n_ovf;
    logic [LW-1:0]        r_b, n_b;
    logic                 r_fin, n_fin;
    lcpie_pkg::t_out_item r_pend, n_pend;
    logic                 r_pend_valid, n_pend_valid;
    lcpie_pkg::t_out_item r_out, n_out;
    logic                 r_out_valid, n_out_valid;

    logic                 w_we;
    logic [AW-1:0]        w_waddr;
    t_entry               w_wdata;
    logic [AW-1:0]        w_raddr;
    logic [ENTRY_W-1:0]   w_rdata;

    lcpie_pkg::t_lbl_req  w_req;
    lcpie_pkg::t_lbl_res  w_res;

    logic [INDEX_BITS-1:0] w_j;
    logic                  w_out_free;
    logic                  w_pop;
    logic                  w_cand;
    logic                  w_done;

    lcpie_stack_mem #(
        .DEPTH  (STACK_DEPTH),
        .DATA_W (ENTRY_W)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    lcpie_label_unit u_label (
        .i_req (w_req),
        .o_res (w_res)
    );

    assign o_in_stall  = (r_state != lcpie_pkg::ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    assign w_j        = r_pos - 1'b1;
    assign w_out_free = !r_out_valid || !i_out_stall;
    // new top after a pop sits one below the entry being dropped
    assign w_raddr    = AW'(r_sp - SP_W'(2));
    assign w_pop      = (r_sp > SP_ONE) && w_res.y_below_bound;
    assign w_cand     = w_res.below_bound && w_res.below_limit;
    assign w_done     = !r_pend_valid || w_out_free;

    // operand selection for the shared label unit
    always_comb begin
        w_req.limit = r_max_len;
        if (r_state == lcpie_pkg::ST_IDLE) begin
            w_req.x     = r_prev;
            w_req.y     = i_in_item.lcp_value;
            w_req.bound = '0;
        end else begin
            w_req.x     = r_top.ol;
            w_req.y     = r_b;
            w_req.bound = r_top.il;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_prev       = r_prev;
        n_pos        = r_pos;
        n_sp         = r_sp;
        n_top        = r_top;
        n_ovf        = r_ovf;
        n_b          = r_b;
        n_fin        = r_fin;
        n_pend       = r_pend;
        n_pend_valid = r_pend_valid;
        n_out        = r_out;
        n_out_valid  = r_out_valid;
        w_we         = 1'b0;
        w_waddr      = r_sp[AW-1:0];
        w_wdata      = '{oi: r_top.ii, ol: r_top.il, ii: r_pos, il: r_b};

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            lcpie_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    if (r_pos == '0) begin
                        // first value seeds the bottom entry
                        if (!i_in_item.last) begin
                            n_top   = '{oi: '0, ol: i_in_item.lcp_value,
                                        ii: '0, il: i_in_item.lcp_value};
                            w_we    = 1'b1;
                            w_waddr = '0;
                            w_wdata = n_top;
                            n_prev  = i_in_item.lcp_value;
                            n_pos   = INDEX_BITS'(1);
                        end
                    end else begin
                        n_b   = i_in_item.lcp_value;
                        n_fin = i_in_item.last;
                        if (w_res.below_limit) begin
                            n_pend.start_index = to_field(w_j);
                            n_pend.end_index   = to_field(w_j);
                            n_pend.repr_index  = '0;
                            n_pend.label       = w_res.label;
                            n_pend.sil         = '0;
                            n_pend.trivial     = 1'b1;
                            n_pend.last_result = 1'b0;
                            n_pend.overflow    = 1'b0;
                            n_pend_valid       = 1'b1;
                        end
                        n_state = lcpie_pkg::ST_POP;
                    end
                end
            end
            lcpie_pkg::ST_POP: begin
                if (w_pop) begin
                    // hold while a second result has nowhere to go
                    if (!(w_cand && r_pend_valid && !w_out_free)) begin
                        if (w_cand) begin
                            if (r_pend_valid) begin
                                n_out             = r_pend;
                                n_out.last_result = 1'b0;
                                n_out.overflow    = r_ovf;
                                n_out_valid       = 1'b1;
                            end
                            n_pend.start_index = to_field(r_top.oi);
                            n_pend.end_index   = to_field(w_j);
                            n_pend.repr_index  = to_field(r_top.ii);
                            n_pend.label       = w_res.label;
                            n_pend.sil         = r_top.il;
                            n_pend.trivial     = 1'b0;
                            n_pend.last_result = 1'b0;
                            n_pend.overflow    = 1'b0;
                            n_pend_valid       = 1'b1;
                        end
                        n_sp    = r_sp - 1'b1;
                        n_state = lcpie_pkg::ST_LOAD;
                    end
                end else begin
                    if (r_sp < SP_FULL) begin
                        w_we  = 1'b1;
                        n_top = w_wdata;
                        n_sp  = r_sp + 1'b1;
                    end else begin
                        n_ovf = 1'b1;
                    end
                    n_prev = r_b;
                    if (r_pos != {INDEX_BITS{1'b1}}) begin
                        n_pos = r_pos + 1'b1;
                    end
                    n_state = lcpie_pkg::ST_FLUSH;
                end
            end
            lcpie_pkg::ST_LOAD: begin
                n_top   = t_entry'(w_rdata);
                n_state = lcpie_pkg::ST_POP;
            end
            lcpie_pkg::ST_FLUSH: begin
                if (r_pend_valid && w_out_free) begin
                    n_out             = r_pend;
                    n_out.last_result = 1'b1;
                    n_out.overflow    = r_ovf;
                    n_out_valid       = 1'b1;
                    n_pend_valid      = 1'b0;
                end
                if (w_done) begin
                    if (r_fin) begin
                        n_prev = '0;
                        n_pos  = '0;
                        n_sp   = SP_ONE;
                        n_top  = '0;
                        n_ovf  = 1'b0;
                    end
                    n_state = lcpie_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = lcpie_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= lcpie_pkg::ST_IDLE;
            r_prev       <= '0;
            r_pos        <= '0;
            r_sp         <= SP_ONE;
            r_top        <= '0;
            r_ovf        <= 1'b0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_prev       <= n_prev;
            r_pos        <= n_pos;
            r_sp         <= n_sp;
            r_top        <= n_top;
            r_ovf        <= n_ovf;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len <= lcpie_pkg::MAX_LENGTH_RESET;
        end else if (i_cfg_we) begin
            r_max_len <= i_cfg_wdata;
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        r_b    <= n_b;
        r_fin  <= n_fin;
        r_pend <= n_pend;
        r_out  <= n_out;
    end

    a_sp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_sp >= SP_ONE) && (r_sp <= SP_FULL))
        else $error("stack pointer out of range");

    a_idle_no_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lcpie_pkg::ST_IDLE) |-> !r_pend_valid)
        else $error("result left in hold buffer at idle");

    a_load_after_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lcpie_pkg::ST_POP) && (n_state == lcpie_pkg::ST_LOAD)
        |=> (r_sp == $past(r_sp) - 1'b1))
        else $error("reload without a pop");

    a_seq_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lcpie_pkg::ST_FLUSH) && w_done && r_fin
        |=> (r_pos == '0) && (r_sp == SP_ONE) && !r_ovf)
        else $error("sequence state not cleared after last item");

endmodule

`default_nettype wire
